// File: rtl/core/mie_pkg.sv
// Shared types and constants for the market impact estimator.
// Used by the top level and by the pipeline module; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

  // Register map: register index is paddr[2].
  typedef enum logic [0:0] {
    REG_PERM_GAIN = 1'b0,
    REG_TEMP_GAIN = 1'b1
  } mie_reg_t;

  typedef struct packed {
    logic [31:0] permanent_gain;
    logic [31:0] temporary_gain;
  } mie_cfg_t;

  localparam logic [62:0] SAT63   = {63{1'b1}};
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

endpackage

`default_nettype wire

// File: rtl/core/mie_pipe.sv
// Arithmetic pipeline of the market impact estimator with output register and skid word.
// Depends on mie_pkg for the configuration struct and constants.
`timescale 1ns / 1ps
`default_nettype none

module mie_pipe
  import mie_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mie_cfg_t           cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [47:0]        order_qty,
  input  wire logic               is_buy,
  input  wire logic [47:0]        ask_depth,
  input  wire logic [47:0]        bid_depth,
  input  wire logic [31:0]        volatility,
  input  wire logic [47:0]        mid_price,
  input  wire logic [47:0]        spread_width,
  input  wire logic [31:0]        imbalance_ratio,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      total_impact,
  output logic [62:0]             permanent_part,
  output logic [62:0]             temporary_part,
  output logic                    saturated
);

  localparam int QW  = 48 + FRAC_BITS;
  localparam int RW  = (QW + 1) / 2;
  localparam int SW  = 2 * RW;
  localparam int RMW = RW + 2;
  localparam int NF  = QW;
  localparam int AW  = FRAC_BITS + 6;
  localparam int APW = AW + 32;
  localparam int GPW = FRAC_BITS + 34;
  localparam logic [62:0]        ONE63   = 63'd1 << FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE_R   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [79:0]        LIQ_LIM = 80'h7FFF_FFFF_FFFF_FFFF - (80'd1 << FRAC_BITS);

  typedef struct packed {
    logic                 buy;
    logic [47:0]          qty;
    logic [31:0]          vol;
    logic [47:0]          mid;
    logic [48:0]          depth;
    logic                 depth_nz;
    logic                 qty_ge;
    logic                 both_nz;
    logic                 liq_en;
    logic                 imb_zero;
    logic [48:0]          rd_rem;
    logic [FRAC_BITS-1:0] rd_q;
    logic [QW-1:0]        ld_nq;
    logic [47:0]          ld_rem;
    logic [SW-1:0]        sq_rad;
    logic [RMW-1:0]       sq_rem;
    logic [RW-1:0]        sq_root;
    logic [4:0]           ln_n;
    logic [30:0]          ln_m;
    logic [FRAC_BITS-1:0] ln_frac;
    logic [AW-1:0]        ln_mag;
  } front_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  typedef struct packed {
    logic signed [63:0] total;
    logic [62:0]        perm;
    logic [62:0]        temp;
    logic               sat;
  } res_t;

  function automatic pp_t qmul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t r;
    r.ll = 64'(a[31:0]) * 64'(b[31:0]);
    r.lh = 64'(a[31:0]) * 64'(b[63:32]);
    r.hl = 64'(a[63:32]) * 64'(b[31:0]);
    r.hh = 64'(a[63:32]) * 64'(b[63:32]);
    return r;
  endfunction

  // Returns the clamp flag in bit 63 and the clamped value below it.
  function automatic logic [63:0] qmul_fin(input pp_t p);
    logic [127:0] w;
    logic [127:0] s;
    w = 128'(p.ll) + (128'(p.lh) << 32) + (128'(p.hl) << 32) + (128'(p.hh) << 64);
    s = w >> FRAC_BITS;
    if (s[127:63] != '0) begin
      return {1'b1, SAT63};
    end
    return {1'b0, s[62:0]};
  endfunction

  logic en;
  assign en = in_ready;

  // Front section: dividers, square root and logarithm, one step per stage.
  front_t      fr      [0:NF];
  front_t      fr_next [0:NF];
  logic [NF:0] fr_v;

  always_comb begin : c_entry
    logic [4:0]  msb;
    logic [31:0] shl;
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (imbalance_ratio[i]) begin
        msb = 5'(i);
      end
    end
    shl = imbalance_ratio << (5'd30 - msb);
    fr_next[0].buy      = is_buy;
    fr_next[0].qty      = order_qty;
    fr_next[0].vol      = volatility;
    fr_next[0].mid      = mid_price;
    fr_next[0].depth    = 49'(ask_depth) + 49'(bid_depth);
    fr_next[0].depth_nz = (ask_depth != '0) || (bid_depth != '0);
    fr_next[0].qty_ge   = 49'(order_qty) >= (49'(ask_depth) + 49'(bid_depth));
    fr_next[0].both_nz  = (ask_depth != '0) && (bid_depth != '0);
    fr_next[0].liq_en   = (mid_price != '0) && (spread_width != '0);
    fr_next[0].imb_zero = (imbalance_ratio == '0);
    fr_next[0].rd_rem   = 49'(order_qty);
    fr_next[0].rd_q     = '0;
    fr_next[0].ld_nq    = {spread_width, {FRAC_BITS{1'b0}}};
    fr_next[0].ld_rem   = '0;
    fr_next[0].sq_rad   = SW'({order_qty, {FRAC_BITS{1'b0}}});
    fr_next[0].sq_rem   = '0;
    fr_next[0].sq_root  = '0;
    fr_next[0].ln_n     = msb;
    fr_next[0].ln_m     = (msb == 5'd31) ? imbalance_ratio[31:1] : shl[30:0];
    fr_next[0].ln_frac  = '0;
    fr_next[0].ln_mag   = '0;
  end

  for (genvar k = 1; k <= NF; k++) begin : g_front
    always_comb begin : c_step
      logic [48:0]    ld_r2;
      logic [49:0]    rd_r2;
      logic [RW+3:0]  sq_r2;
      logic [RW+3:0]  sq_t;
      logic [61:0]    ln_p;
      logic [AW-1:0]  ln_a;
      logic [APW-1:0] ln_q;
      fr_next[k] = fr[k-1];

      ld_r2 = {fr[k-1].ld_rem, fr[k-1].ld_nq[QW-1]};
      if (ld_r2 >= {1'b0, fr[k-1].mid}) begin
        fr_next[k].ld_rem = 48'(ld_r2 - {1'b0, fr[k-1].mid});
        fr_next[k].ld_nq  = {fr[k-1].ld_nq[QW-2:0], 1'b1};
      end else begin
        fr_next[k].ld_rem = ld_r2[47:0];
        fr_next[k].ld_nq  = {fr[k-1].ld_nq[QW-2:0], 1'b0};
      end

      rd_r2 = {fr[k-1].rd_rem, 1'b0};
      if (k <= FRAC_BITS) begin
        if (rd_r2 >= 50'(fr[k-1].depth)) begin
          fr_next[k].rd_rem = 49'(rd_r2 - 50'(fr[k-1].depth));
          fr_next[k].rd_q   = {fr[k-1].rd_q[FRAC_BITS-2:0], 1'b1};
        end else begin
          fr_next[k].rd_rem = rd_r2[48:0];
          fr_next[k].rd_q   = {fr[k-1].rd_q[FRAC_BITS-2:0], 1'b0};
        end
      end

      sq_r2 = {fr[k-1].sq_rem, fr[k-1].sq_rad[SW-1 -: 2]};
      sq_t  = {2'b00, fr[k-1].sq_root, 2'b01};
      if (k <= RW) begin
        fr_next[k].sq_rad = {fr[k-1].sq_rad[SW-3:0], 2'b00};
        if (sq_r2 >= sq_t) begin
          fr_next[k].sq_rem  = RMW'(sq_r2 - sq_t);
          fr_next[k].sq_root = {fr[k-1].sq_root[RW-2:0], 1'b1};
        end else begin
          fr_next[k].sq_rem  = RMW'(sq_r2);
          fr_next[k].sq_root = {fr[k-1].sq_root[RW-2:0], 1'b0};
        end
      end

      ln_p = 62'(fr[k-1].ln_m) * 62'(fr[k-1].ln_m);
      if (k <= FRAC_BITS) begin
        if (ln_p[61]) begin
          fr_next[k].ln_m    = ln_p[61:31];
          fr_next[k].ln_frac = {fr[k-1].ln_frac[FRAC_BITS-2:0], 1'b1};
        end else begin
          fr_next[k].ln_m    = ln_p[60:30];
          fr_next[k].ln_frac = {fr[k-1].ln_frac[FRAC_BITS-2:0], 1'b0};
        end
      end

      if (fr[k-1].ln_n >= 5'(FRAC_BITS)) begin
        ln_a = (AW'(fr[k-1].ln_n - 5'(FRAC_BITS)) << FRAC_BITS) | AW'(fr[k-1].ln_frac);
      end else begin
        ln_a = (AW'(5'(FRAC_BITS) - fr[k-1].ln_n) << FRAC_BITS) - AW'(fr[k-1].ln_frac);
      end
      ln_q = APW'(ln_a) * APW'(LN2_Q32);
      if (k == FRAC_BITS + 1) begin
        fr_next[k].ln_mag = ln_q[APW-1:32];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fr[k] <= fr_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr[0] <= fr_next[0];
    end
  end

  // Back section: multiplier chain.
  logic [7:1] bv;

  logic              b1_buy, b1_sat;
  logic [47:0]       b1_qty;
  logic [31:0]       b1_vol;
  logic [33:0]       b1_gamma;
  logic [63:0]       b1_tv;
  logic [RW-1:0]     b1_root;
  logic [62:0]       b1_liq, b1_imf;

  logic              b2_buy, b2_sat;
  logic [47:0]       b2_qty;
  logic [63:0]       b2_gv;
  pp_t               b2_pp;
  logic [62:0]       b2_liq, b2_imf;

  logic              b3_buy, b3_sat;
  logic [62:0]       b3_t1, b3_liq, b3_imf;
  pp_t               b3_pp;

  logic              b4_buy, b4_sat;
  logic [62:0]       b4_perm, b4_imf;
  pp_t               b4_pp;

  logic              b5_buy, b5_sat;
  logic [62:0]       b5_perm, b5_t2, b5_imf;

  logic              b6_buy, b6_sat;
  logic [62:0]       b6_perm;
  pp_t               b6_pp;

  logic              b7_buy, b7_sat;
  logic [62:0]       b7_perm, b7_temp;

  logic [FRAC_BITS:0]   b1_ratio;
  logic [FRAC_BITS+1:0] b1_opr;
  logic [GPW-1:0]       b1_gp;
  logic [63:0]          b1_tp;
  logic [79:0]          b1_lq;
  logic [62:0]          b1_liq_next, b1_imf_next;
  logic                 b1_liq_sat, b1_imf_sat;
  logic [65:0]          b2_gp;
  logic [63:0]          b3_fin, b4_fin, b5_fin, b7_fin;

  always_comb begin
    b1_ratio = fr[NF].qty_ge ? ONE_R : {1'b0, fr[NF].rd_q};
    b1_opr   = {1'b0, b1_ratio} + {1'b0, ONE_R};
    b1_gp    = GPW'(cfg.permanent_gain) * GPW'(b1_opr);
    b1_tp    = 64'(cfg.temporary_gain) * 64'(fr[NF].vol);
    b1_lq    = 80'(fr[NF].ld_nq);
    b1_liq_sat = 1'b0;
    b1_imf_sat = 1'b0;
    if (!fr[NF].liq_en) begin
      b1_liq_next = ONE63;
    end else if (b1_lq > LIQ_LIM) begin
      b1_liq_next = SAT63;
      b1_liq_sat  = 1'b1;
    end else begin
      b1_liq_next = 63'(b1_lq) + ONE63;
    end
    if (!fr[NF].both_nz) begin
      b1_imf_next = ONE63;
    end else if (fr[NF].imb_zero) begin
      b1_imf_next = SAT63;
      b1_imf_sat  = 1'b1;
    end else if (63'(fr[NF].ln_mag) > ONE63) begin
      b1_imf_next = 63'(fr[NF].ln_mag);
    end else begin
      b1_imf_next = ONE63;
    end
    b2_gp  = 66'(b1_gamma) * 66'(b1_vol);
    b3_fin = qmul_fin(b2_pp);
    b4_fin = qmul_fin(b3_pp);
    b5_fin = qmul_fin(b4_pp);
    b7_fin = qmul_fin(b6_pp);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_buy   <= fr[NF].buy;
      b1_qty   <= fr[NF].qty;
      b1_vol   <= fr[NF].vol;
      b1_gamma <= fr[NF].depth_nz ? b1_gp[GPW-1:FRAC_BITS] : 34'(cfg.permanent_gain);
      b1_tv    <= 64'(b1_tp >> FRAC_BITS);
      b1_root  <= fr[NF].sq_root;
      b1_liq   <= b1_liq_next;
      b1_imf   <= b1_imf_next;
      b1_sat   <= b1_liq_sat | b1_imf_sat;

      b2_buy <= b1_buy;
      b2_sat <= b1_sat;
      b2_qty <= b1_qty;
      b2_gv  <= 64'(b2_gp >> FRAC_BITS);
      b2_pp  <= qmul_pp(b1_tv, 64'(b1_root));
      b2_liq <= b1_liq;
      b2_imf <= b1_imf;

      b3_buy <= b2_buy;
      b3_sat <= b2_sat | b3_fin[63];
      b3_t1  <= b3_fin[62:0];
      b3_pp  <= qmul_pp(b2_gv, 64'(b2_qty));
      b3_liq <= b2_liq;
      b3_imf <= b2_imf;

      b4_buy  <= b3_buy;
      b4_sat  <= b3_sat | b4_fin[63];
      b4_perm <= b4_fin[62:0];
      b4_pp   <= qmul_pp(64'(b3_t1), 64'(b3_liq));
      b4_imf  <= b3_imf;

      b5_buy  <= b4_buy;
      b5_sat  <= b4_sat | b5_fin[63];
      b5_perm <= b4_perm;
      b5_t2   <= b5_fin[62:0];
      b5_imf  <= b4_imf;

      b6_buy  <= b5_buy;
      b6_sat  <= b5_sat;
      b6_perm <= b5_perm;
      b6_pp   <= qmul_pp(64'(b5_t2), 64'(b5_imf));

      b7_buy  <= b6_buy;
      b7_sat  <= b6_sat | b7_fin[63];
      b7_perm <= b6_perm;
      b7_temp <= b7_fin[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_v <= '0;
      bv   <= '0;
    end else if (en) begin
      fr_v <= {fr_v[NF-1:0], in_valid};
      bv   <= {bv[6:1], fr_v[NF]};
    end
  end

  // Result word, output register and skid word.
  res_t        res, out_word, skid_word;
  logic [63:0] sum;
  logic        push, skid_full;

  always_comb begin
    sum     = {1'b0, b7_perm} + {1'b0, b7_temp};
    res.sat = b7_sat;
    if (sum > {1'b0, SAT63}) begin
      sum     = {1'b0, SAT63};
      res.sat = 1'b1;
    end
    res.total = b7_buy ? signed'(sum) : signed'(64'd0 - sum);
    res.perm  = b7_perm;
    res.temp  = b7_temp;
  end

  assign push     = en && bv[7];
  assign in_ready = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_word <= skid_full ? skid_word : res;
    end else if (push) begin
      skid_word <= res;
    end
  end

  assign total_impact   = out_word.total;
  assign permanent_part = out_word.perm;
  assign temporary_part = out_word.temp;
  assign saturated      = out_word.sat;

endmodule

`default_nettype wire

// File: rtl/core/market_impact_estimator_unit.sv
// Throughput: one word per cycle while in_ready is high; a full skid word stalls the pipeline.
// The spread divider (one quotient bit per stage) sets depth.
// Reset (synchronous, active high) clears both gain registers to zero and empties the pipeline.
// Top level of the market impact estimator: register port and pipeline.
// Depends on mie_pkg and mie_pipe.
`timescale 1ns / 1ps
`default_nettype none

module market_impact_estimator_unit
  import mie_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [47:0]   order_qty,
  input  wire logic          is_buy,
  input  wire logic [47:0]   ask_depth,
  input  wire logic [47:0]   bid_depth,
  input  wire logic [31:0]   volatility,
  input  wire logic [47:0]   mid_price,
  input  wire logic [47:0]   spread_width,
  input  wire logic [31:0]   imbalance_ratio,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic signed [63:0] total_impact,
  output logic [62:0]        permanent_part,
  output logic [62:0]        temporary_part,
  output logic               saturated
);

  mie_cfg_t cfg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (mie_reg_t'(paddr[2]))
        REG_PERM_GAIN: cfg.permanent_gain <= pwdata;
        REG_TEMP_GAIN: cfg.temporary_gain <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (mie_reg_t'(paddr[2]))
      REG_PERM_GAIN: prdata = cfg.permanent_gain;
      REG_TEMP_GAIN: prdata = cfg.temporary_gain;
    endcase
  end

  mie_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_pipe (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .order_qty      (order_qty),
    .is_buy         (is_buy),
    .ask_depth      (ask_depth),
    .bid_depth      (bid_depth),
    .volatility     (volatility),
    .mid_price      (mid_price),
    .spread_width   (spread_width),
    .imbalance_ratio(imbalance_ratio),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .total_impact   (total_impact),
    .permanent_part (permanent_part),
    .temporary_part (temporary_part),
    .saturated      (saturated)
  );

endmodule

`default_nettype wire

// File: rtl/core/mie_checker.sv
// Port-level checks for the market impact estimator and the bind that attaches them.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module mie_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [63:0] total_impact,
  input wire logic [62:0]        permanent_part,
  input wire logic [62:0]        temporary_part,
  input wire logic               saturated
);

  logic [63:0] mag;
  assign mag = {1'b0, permanent_part} + {1'b0, temporary_part};

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_impact) && $stable(saturated))
    else $error("stalled output word changed");

  a_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && !saturated |->
      (64'(total_impact) == mag) || (64'(total_impact) == 64'd0 - mag))
    else $error("total impact does not match its parts");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without a blocked output word");

endmodule

bind market_impact_estimator_unit mie_checker u_mie_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .total_impact  (total_impact),
  .permanent_part(permanent_part),
  .temporary_part(temporary_part),
  .saturated     (saturated)
);

`default_nettype wire

// File: sim/testbench.sv
// Testbench for market_impact_estimator_unit: fixed-result table, then directed and random
// orders checked against an in-bench fixed-point predictor. Depends on mie_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import mie_pkg::*;

  localparam int FB = 16;
  localparam logic [63:0] SATV = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE = 64'd1 << FB;
  localparam int LATENCY = FB + 57;

  typedef struct packed {
    logic [47:0] qty;
    logic        buy;
    logic [47:0] ask;
    logic [47:0] bid;
    logic [31:0] vol;
    logic [47:0] mid;
    logic [47:0] spr;
    logic [31:0] imb;
  } order_t;

  typedef struct packed {
    logic [63:0] total;
    logic [62:0] perm;
    logic [62:0] temp;
    logic        sat;
  } impact_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  order_t cur = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [63:0] total_impact;
  logic [62:0] permanent_part, temporary_part;
  logic saturated;

  logic [31:0] gain_perm, gain_temp;
  impact_t expected_impacts[$];
  int errors = 0;
  int results_seen = 0;
  int orders_sent = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  always #6 clk = ~clk;

  market_impact_estimator_unit dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready,
    .order_qty(cur.qty), .is_buy(cur.buy), .ask_depth(cur.ask), .bid_depth(cur.bid),
    .volatility(cur.vol), .mid_price(cur.mid), .spread_width(cur.spr),
    .imbalance_ratio(cur.imb),
    .out_valid, .out_ready, .total_impact, .permanent_part, .temporary_part, .saturated
  );

  function automatic logic [63:0] scale_mul(input logic [63:0] a, input logic [63:0] b,
                                             inout bit clamped);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> FB;
    if (p > {64'd0, SATV}) begin
      clamped = 1;
      return SATV;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] abs_log(input logic [31:0] v);
    int n;
    logic [63:0] m, frac, a;
    longint l2;
    n = 31;
    while (n > 0 && v[n] == 1'b0) n--;
    m = (n <= 30) ? ({32'd0, v} << (30 - n)) : ({32'd0, v} >> (n - 30));
    frac = 0;
    for (int i = 0; i < FB; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    l2 = (longint'(n) - FB) * (longint'(1) << FB) + longint'(frac);
    a = (l2 < 0) ? 64'(-l2) : 64'(l2);
    return 64'(({64'd0, a} * 128'd2977044472) >> 32);
  endfunction

  function automatic impact_t estimate_impact(input order_t o);
    impact_t r;
    bit clamped;
    logic [63:0] depth, gamma, ratio, perm, liq, imf, temp, root, l, sum;
    logic [127:0] q, x;
    clamped = 0;
    depth = 64'(o.ask) + 64'(o.bid);
    gamma = 64'(gain_perm);
    if (depth != 0) begin
      q = ({80'd0, o.qty} << FB) / {64'd0, depth};
      ratio = (q > {64'd0, ONE}) ? ONE : q[63:0];
      gamma = scale_mul(gamma, ONE + ratio, clamped);
    end
    perm = scale_mul(scale_mul(gamma, 64'(o.vol), clamped), 64'(o.qty), clamped);
    liq = ONE;
    if (o.mid != 0 && o.spr != 0) begin
      q = ({80'd0, o.spr} << FB) / {80'd0, o.mid};
      if (q > {64'd0, SATV - ONE}) begin
        clamped = 1;
        liq = SATV;
      end else liq = ONE + q[63:0];
    end
    imf = ONE;
    if (o.ask != 0 && o.bid != 0) begin
      if (o.imb == 0) begin
        clamped = 1;
        imf = SATV;
      end else begin
        l = abs_log(o.imb);
        imf = (l > ONE) ? l : ONE;
      end
    end
    x = {80'd0, o.qty} << FB;
    root = 0;
    for (int b = 39; b >= 0; b--) begin
      logic [63:0] c;
      c = root | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= x) root = c;
    end
    temp = scale_mul(64'(gain_temp), 64'(o.vol), clamped);
    temp = scale_mul(temp, root, clamped);
    temp = scale_mul(temp, liq, clamped);
    temp = scale_mul(temp, imf, clamped);
    sum = perm + temp;
    if (sum > SATV) begin
      clamped = 1;
      sum = SATV;
    end
    r.total = o.buy ? sum : -sum;
    r.perm = perm[62:0];
    r.temp = temp[62:0];
    r.sat = clamped;
    return r;
  endfunction

  task automatic write_gain(input mie_reg_t idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == REG_PERM_GAIN) gain_perm = val;
    else gain_temp = val;
    @(posedge clk);
  endtask

  task automatic send_order(input order_t o, input bit has_fixed, input impact_t fixed);
    cur <= o;
    in_valid <= 1;
    expected_impacts.push_back(has_fixed ? fixed : estimate_impact(o));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    orders_sent++;
  endtask

  task automatic drain_pipeline;
    in_valid <= 0;
    while (expected_impacts.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic order_t random_order;
    order_t o;
    int shape;
    o.buy = 1'($urandom_range(0, 1));
    shape = $urandom_range(0, 9);
    o.qty = shape == 0 ? 48'({$urandom, $urandom}) :
            48'($urandom_range(0, 32'h00FF_FFFF)) << 4;
    o.ask = shape == 1 ? 48'd0 : 48'({$urandom, $urandom} >> $urandom_range(0, 40));
    o.bid = shape == 2 ? 48'd0 : 48'({$urandom, $urandom} >> $urandom_range(0, 40));
    o.vol = $urandom >> $urandom_range(0, 24);
    o.mid = shape == 3 ? 48'd0 : 48'({$urandom, $urandom} >> $urandom_range(0, 30));
    o.spr = shape == 4 ? 48'd0 : 48'({$urandom, $urandom} >> $urandom_range(0, 40));
    o.imb = shape == 5 ? 32'd0 : $urandom >> $urandom_range(0, 28);
    return o;
  endfunction

  typedef struct {
    order_t o;
    bit has_fixed;
    impact_t fixed;
  } table_row_t;

  table_row_t rows[$];
  order_t dir_orders[$];
  logic [31:0] gain_sets[4][2] = '{'{32'd0, 32'd0}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
                                   '{32'h0001_0000, 32'h0000_8000}, '{32'h0000_0001, 32'h0123_4567}};

  initial begin
    table_row_t row;
    order_t o;
    int burst;
    int gap;
    gain_perm = 0;
    gain_temp = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    row.has_fixed = 1;
    row.o = '{qty: 48'hFFFF_FFFF_FFFF, buy: 1, ask: 48'hFFFF_FFFF_FFFF, bid: 48'hFFFF_FFFF_FFFF,
              vol: 32'hFFFF_FFFF, mid: 48'hFFFF_FFFF_FFFF, spr: 48'hFFFF_FFFF_FFFF, imb: 32'hFFFF_FFFF};
    row.fixed = '{total: 64'd0, perm: 63'd0, temp: 63'd0, sat: 1'b0};
    rows.push_back(row);
    row.o = '{qty: 48'd0, buy: 0, ask: 48'd5, bid: 48'd7, vol: 32'd0, mid: 48'd0, spr: 48'd0,
              imb: 32'd0};
    row.fixed = '{total: 64'd0, perm: 63'd0, temp: 63'd0, sat: 1'b1};
    rows.push_back(row);
    foreach (rows[i]) send_order(rows[i].o, 1, rows[i].fixed);
    drain_pipeline();

    o = '{qty: 48'hFFFF_FFFF_FFFF, buy: 1, ask: 48'hFFFF_FFFF_FFFF, bid: 48'hFFFF_FFFF_FFFF,
          vol: 32'hFFFF_FFFF, mid: 48'd1, spr: 48'hFFFF_FFFF_FFFF, imb: 32'hFFFF_FFFF};
    dir_orders.push_back(o);
    o = '{qty: 48'h1_0000, buy: 0, ask: 48'h1_0000, bid: 48'd0, vol: 32'h1_0000,
          mid: 48'h10_0000, spr: 48'h1_0000, imb: 32'd1};
    dir_orders.push_back(o);
    o = '{qty: 48'h4_0000, buy: 1, ask: 48'h1_0000, bid: 48'h1_0000, vol: 32'h2_0000,
          mid: 48'h64_0000, spr: 48'd0, imb: 32'd0};
    dir_orders.push_back(o);
    o = '{qty: 48'h9_0000, buy: 0, ask: 48'h20_0000, bid: 48'h30_0000, vol: 32'h8000,
          mid: 48'h64_0000, spr: 48'h8000, imb: 32'h1_0000};
    dir_orders.push_back(o);
    o.imb = 32'h20_0000;
    dir_orders.push_back(o);

    for (int g = 0; g < 4; g++) begin
      write_gain(REG_PERM_GAIN, gain_sets[g][0]);
      write_gain(REG_TEMP_GAIN, gain_sets[g][1]);
      foreach (dir_orders[i]) send_order(dir_orders[i], 0, '0);
      for (int k = 0; k < 20; k++) begin
        burst = $urandom_range(1, 40);
        repeat (burst) send_order(random_order(), 0, '0);
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
          in_valid <= 0;
          repeat (gap) @(posedge clk);
        end
        if (k == 10 && g == 1) hold_off = 1;
      end
      drain_pipeline();
      write_gain(REG_PERM_GAIN, $urandom);
      write_gain(REG_TEMP_GAIN, $urandom >> $urandom_range(0, 16));
    end
    stim_done = 1;
  end

  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      phase++;
      out_ready <= (phase % 37 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    impact_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_impacts.size() == 0) begin
        errors++;
        $display("%t unexpected word total=%h", $realtime, total_impact);
      end else begin
        exp_r = expected_impacts.pop_front();
        if (exp_r.total !== total_impact) begin
          errors++;
          $display("%t total_impact expected %h actual %h", $realtime, exp_r.total, total_impact);
        end
        if (exp_r.perm !== permanent_part) begin
          errors++;
          $display("%t permanent_part expected %h actual %h", $realtime, exp_r.perm,
                   permanent_part);
        end
        if (exp_r.temp !== temporary_part) begin
          errors++;
          $display("%t temporary_part expected %h actual %h", $realtime, exp_r.temp,
                   temporary_part);
        end
        if (exp_r.sat !== saturated) begin
          errors++;
          $display("%t saturated expected %b actual %b", $realtime, exp_r.sat, saturated);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    $display("Sent %0d orders over four gain settings and checked %0d results.", orders_sent,
             results_seen);
    if (errors == 0 && expected_impacts.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
